// ===== rtl/sdps_pkg.sv =====
// ----------------------------------------------------------------------------
// sdps_pkg
// Shared types, register codes and constants of the soft dot pattern shader.
// ----------------------------------------------------------------------------
package sdps_pkg;

  // Default parameter values
  localparam int COORD_FRAC_BITS = 16;
  localparam int CHANNEL_BITS    = 8;

  // Fixed field widths
  localparam int COORD_W    = 24;
  localparam int SCALE_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int SQ_W       = 32;
  localparam int COV_W      = 17;
  localparam int ROOT_STEPS = 16;
  localparam int DIV_STEPS  = 16;

  localparam logic [COV_W-1:0]          ONE_Q16       = 17'h10000;
  localparam logic signed [SCALE_W-1:0] SCALE_DEFAULT = 16'sd2048;

  // Register reset values
  localparam logic [15:0] CELL_SCALE_RST = 16'd2048;
  localparam logic [16:0] DOT_RADIUS_RST = 17'd22938;
  localparam logic [16:0] SOFTNESS_RST   = 17'd3277;
  localparam logic [23:0] BG_RGB_RST     = 24'hEBEBEB;
  localparam logic [23:0] DOT_RGB_RST    = 24'h1A1A1A;

  // Register indexes
  typedef enum logic [2:0] {
    CFG_CELL_SCALE = 3'd0,
    CFG_DOT_RADIUS = 3'd1,
    CFG_SOFTNESS   = 3'd2,
    CFG_BG_RGB     = 3'd3,
    CFG_DOT_RGB    = 3'd4
  } cfg_reg_e;

  // Coverage outcome carried down the divider chain
  typedef enum logic [1:0] {
    COV_FULL = 2'd0,
    COV_ZERO = 2'd1,
    COV_DIV  = 2'd2
  } cov_mode_e;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_beat_t;

  typedef struct packed {
    cov_mode_e         mode;
    logic [COV_W-1:0]  rem;
    logic [FRAC_W-1:0] quo;
  } div_beat_t;

endpackage

// ===== rtl/soft_dot_pattern_shader.sv =====
// ----------------------------------------------------------------------------
// soft_dot_pattern_shader
// Procedural polka dot texture: coordinate pair in, blended RGB and coverage.
// ----------------------------------------------------------------------------
// Usage:
//   Drive u_coord_i / v_coord_i and raise start_i; a beat is taken at each
//   rising edge with start_i high and busy_o low. busy_o stays low, so one
//   beat per cycle is taken with no gaps.
//   Each result shows on red/green/blue_out_o and coverage_o for one cycle
//   with valid_o high. Results come in order; the receiver cannot stall,
//   so none is ever held back.
//   The pipeline holds two cell rows: 16 square root cells and 16
//   divider cells, one digit per cell, plus five arithmetic stages.
//   Configuration beats use cfg_valid_i / cfg_ready_o with cfg_index_i
//   and cfg_data_i; cfg_ready_o is always high. Write registers only while
//   no result is pending.
//   Reset clears the pipeline valid bits and loads the register defaults;
//   the block accepts a beat in the first cycle after reset.
// ----------------------------------------------------------------------------
module soft_dot_pattern_shader import sdps_pkg::*; #(
  parameter int CoordFracBits = COORD_FRAC_BITS,
  parameter int ChannelBits   = CHANNEL_BITS,
  localparam int RgbW = 3 * ChannelBits,
  localparam int CfgW = (RgbW > COV_W) ? RgbW : COV_W
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [COORD_W-1:0] u_coord_i,
  input  logic signed [COORD_W-1:0] v_coord_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [2:0]                cfg_index_i,
  input  logic [CfgW-1:0]           cfg_data_i,
  output logic                      valid_o,
  output logic [ChannelBits-1:0]    red_out_o,
  output logic [ChannelBits-1:0]    green_out_o,
  output logic [ChannelBits-1:0]    blue_out_o,
  output logic [COV_W-1:0]          coverage_o
);

  localparam int ProdW    = COORD_W + SCALE_W;
  localparam int ProdFrac = CoordFracBits + 8;
  localparam int MixW     = ChannelBits + COV_W + 1;

  // Configuration registers
  logic [SCALE_W-1:0] cell_scale_q;
  logic [COV_W-1:0]   dot_radius_q, softness_q;
  logic [RgbW-1:0]    bg_rgb_q, dot_rgb_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_scale_q <= CELL_SCALE_RST;
      dot_radius_q <= DOT_RADIUS_RST;
      softness_q   <= SOFTNESS_RST;
      bg_rgb_q     <= RgbW'(BG_RGB_RST);
      dot_rgb_q    <= RgbW'(DOT_RGB_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CELL_SCALE: cell_scale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_DOT_RADIUS: dot_radius_q <= cfg_data_i[COV_W-1:0];
        CFG_SOFTNESS:   softness_q   <= cfg_data_i[COV_W-1:0];
        CFG_BG_RGB:     bg_rgb_q     <= cfg_data_i[RgbW-1:0];
        CFG_DOT_RGB:    dot_rgb_q    <= cfg_data_i[RgbW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp radius and softness to one, softness at least one LSB
  logic [COV_W-1:0] radius_c, soft_c, soft_sat;
  assign radius_c = (dot_radius_q > ONE_Q16) ? ONE_Q16 : dot_radius_q;
  assign soft_sat = (softness_q > ONE_Q16) ? ONE_Q16 : softness_q;
  assign soft_c   = (soft_sat == '0) ? COV_W'(1) : soft_sat;

  // Stage 1: scale both coordinates
  logic signed [SCALE_W-1:0] scale_c;
  logic signed [ProdW-1:0]   prod_u_q, prod_v_q;
  logic                      s1_valid_q;

  assign scale_c = (cell_scale_q == '0) ? SCALE_DEFAULT : $signed(cell_scale_q);

  always_ff @(posedge clk_i) begin
    prod_u_q <= ProdW'(u_coord_i) * ProdW'(scale_c);
    prod_v_q <= ProdW'(v_coord_i) * ProdW'(scale_c);
  end

  // Stage 2: centered cell offsets, squared distance
  logic [FRAC_W-1:0]        fr_u, fr_v;
  logic signed [FRAC_W-1:0] off_u, off_v;
  logic signed [SQ_W-1:0]   sq_u, sq_v;
  logic [SQ_W-1:0]          dist_sq_q;
  logic                     s2_valid_q;

  assign fr_u  = prod_u_q[ProdFrac-1 -: FRAC_W];
  assign fr_v  = prod_v_q[ProdFrac-1 -: FRAC_W];
  assign off_u = $signed({~fr_u[FRAC_W-1], fr_u[FRAC_W-2:0]});
  assign off_v = $signed({~fr_v[FRAC_W-1], fr_v[FRAC_W-2:0]});
  assign sq_u  = SQ_W'(off_u) * SQ_W'(off_u);
  assign sq_v  = SQ_W'(off_v) * SQ_W'(off_v);

  always_ff @(posedge clk_i) begin
    dist_sq_q <= $unsigned(sq_u) + $unsigned(sq_v);
  end

  // Square root cell row
  logic       sq_valid [ROOT_STEPS+1];
  sqrt_beat_t sq_beat  [ROOT_STEPS+1];

  assign sq_valid[0]     = s2_valid_q;
  assign sq_beat[0].rem  = dist_sq_q;
  assign sq_beat[0].root = '0;

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_sqrt
    sdps_sqrt_cell #(.Step(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[k]),
      .beat_i  (sq_beat[k]),
      .valid_o (sq_valid[k+1]),
      .beat_o  (sq_beat[k+1])
    );
  end

  // Stage 3: distance past the radius, pick coverage case
  logic signed [COV_W:0] diff;
  div_beat_t             dv_init_d, dv_init_q;
  logic                  dv_init_valid_q;

  always_comb begin
    diff = $signed({2'b00, sq_beat[ROOT_STEPS].root[FRAC_W-1:0]})
         - $signed({1'b0, radius_c});
    dv_init_d.rem = diff[COV_W-1:0];
    dv_init_d.quo = '0;
    if (diff <= 0) begin
      dv_init_d.mode = COV_FULL;
    end else if (diff[COV_W-1:0] >= soft_c) begin
      dv_init_d.mode = COV_ZERO;
    end else begin
      dv_init_d.mode = COV_DIV;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_init_q <= dv_init_d;
  end

  // Divider cell row
  logic      dv_valid [DIV_STEPS+1];
  div_beat_t dv_beat  [DIV_STEPS+1];

  assign dv_valid[0] = dv_init_valid_q;
  assign dv_beat[0]  = dv_init_q;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    sdps_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[k]),
      .beat_i  (dv_beat[k]),
      .soft_i  (soft_c),
      .valid_o (dv_valid[k+1]),
      .beat_o  (dv_beat[k+1])
    );
  end

  // Stage 4: coverage
  logic [COV_W-1:0] t_d, t_q;
  logic             t_valid_q;

  always_comb begin
    case (dv_beat[DIV_STEPS].mode)
      COV_FULL: t_d = ONE_Q16;
      COV_ZERO: t_d = '0;
      COV_DIV:  t_d = ONE_Q16 - {1'b0, dv_beat[DIV_STEPS].quo};
      default:  t_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
  end

  // Stage 5: blend each channel
  logic [ChannelBits-1:0] chan_d [3];
  logic [ChannelBits-1:0] chan_q [3];
  logic [COV_W-1:0]       cov_q;
  logic                   out_valid_q;
  logic [MixW-1:0]        mix [3];
  logic [COV_W-1:0]       t_inv;

  assign t_inv = ONE_Q16 - t_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mix[c] = MixW'(bg_rgb_q[(2 - c) * ChannelBits +: ChannelBits]) * MixW'(t_inv)
             + MixW'(dot_rgb_q[(2 - c) * ChannelBits +: ChannelBits]) * MixW'(t_q)
             + MixW'(32768);
      chan_d[c] = mix[c][FRAC_W +: ChannelBits];
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q <= chan_d;
    cov_q  <= t_q;
  end

  // Advance valid bits of the arithmetic stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q      <= 1'b0;
      s2_valid_q      <= 1'b0;
      dv_init_valid_q <= 1'b0;
      t_valid_q       <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      s1_valid_q      <= start_i && !busy_o;
      s2_valid_q      <= s1_valid_q;
      dv_init_valid_q <= sq_valid[ROOT_STEPS];
      t_valid_q       <= dv_valid[DIV_STEPS];
      out_valid_q     <= t_valid_q;
    end
  end

  assign valid_o     = out_valid_q;
  assign red_out_o   = chan_q[0];
  assign green_out_o = chan_q[1];
  assign blue_out_o  = chan_q[2];
  assign coverage_o  = cov_q;

  // Checks
  a_cov_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> coverage_o <= ONE_Q16)
    else $error("coverage above one");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid[ROOT_STEPS] |-> sq_beat[ROOT_STEPS].root[SQ_W-1:FRAC_W] == '0)
    else $error("square root wider than 16 bits");

  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_valid_q |=> valid_o)
    else $error("coverage beat lost before output");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(t_valid_q))
    else $error("output strobe without a coverage beat");

endmodule

// ===== rtl/sdps_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// sdps_sqrt_cell
// One digit step of the integer square root, registered.
// ----------------------------------------------------------------------------
module sdps_sqrt_cell import sdps_pkg::*; #(
  parameter int Step = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  sqrt_beat_t beat_i,
  output logic       valid_o,
  output sqrt_beat_t beat_o
);

  localparam logic [SQ_W-1:0] Bit = SQ_W'(1) << (30 - 2 * Step);

  logic       valid_q;
  sqrt_beat_t beat_d, beat_q;
  logic [SQ_W:0] trial;

  // Try the next root digit
  always_comb begin
    trial = {1'b0, beat_i.root} + {1'b0, Bit};
    if ({1'b0, beat_i.rem} >= trial) begin
      beat_d.rem  = beat_i.rem - trial[SQ_W-1:0];
      beat_d.root = (beat_i.root >> 1) + Bit;
    end else begin
      beat_d.rem  = beat_i.rem;
      beat_d.root = beat_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== rtl/sdps_div_cell.sv =====
// ----------------------------------------------------------------------------
// sdps_div_cell
// One restoring division step of the soft edge quotient, registered.
// ----------------------------------------------------------------------------
module sdps_div_cell import sdps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  div_beat_t        beat_i,
  input  logic [COV_W-1:0] soft_i,
  output logic             valid_o,
  output div_beat_t        beat_o
);

  logic      valid_q;
  div_beat_t beat_d, beat_q;
  logic [COV_W:0] shifted;

  // Shift in one numerator zero and subtract the divisor when it fits
  always_comb begin
    shifted     = {beat_i.rem, 1'b0};
    beat_d.mode = beat_i.mode;
    if (shifted >= {1'b0, soft_i}) begin
      beat_d.rem = COV_W'(shifted - {1'b0, soft_i});
      beat_d.quo = {beat_i.quo[FRAC_W-2:0], 1'b1};
    end else begin
      beat_d.rem = shifted[COV_W-1:0];
      beat_d.quo = {beat_i.quo[FRAC_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the soft dot pattern shader. Drives coordinate
// beats with random gaps, reprograms the registers between phases while the
// pipeline is empty, and compares every result with an in-bench predictor.
// ----------------------------------------------------------------------------
module testbench import sdps_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int        RGB_W        = 3 * CHANNEL_BITS;
  localparam int        CFG_W        = (RGB_W > COV_W) ? RGB_W : COV_W;
  localparam int        NUM_PHASES   = 10;
  localparam int        PHASE_ITEMS  = 100;
  localparam int        DRAIN_CYCLES = 40;
  localparam int        CYCLE_LIMIT  = 400000;
  localparam logic [2:0] UNUSED_IDX_LO = 3'd5;

  typedef struct {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic [COV_W-1:0]        cov;
  } shade_t;

  // Scoreboard: register shadow, dot shading predictor, queue of shades
  class shade_scoreboard;
    logic [15:0]      cell_scale;
    logic [16:0]      radius;
    logic [16:0]      softness;
    logic [RGB_W-1:0] bg_rgb;
    logic [RGB_W-1:0] dot_rgb;
    shade_t           pending_shades[$];
    int               mismatches;

    function new();
      cell_scale = CELL_SCALE_RST;
      radius     = DOT_RADIUS_RST;
      softness   = SOFTNESS_RST;
      bg_rgb     = BG_RGB_RST;
      dot_rgb    = DOT_RGB_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_CELL_SCALE: cell_scale = data[15:0];
        CFG_DOT_RADIUS: radius     = data[16:0];
        CFG_SOFTNESS:   softness   = data[16:0];
        CFG_BG_RGB:     bg_rgb     = data[RGB_W-1:0];
        CFG_DOT_RGB:    dot_rgb    = data[RGB_W-1:0];
        default: ;
      endcase
    endfunction

    // Position within the cell, measured from its centre, Q0.16
    function longint cell_offset(longint coord, longint scale);
      longint p;
      p = coord * scale;
      return longint'((p & 64'hFF_FFFF) >> 8) - 32768;
    endfunction

    function void note_input(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
      longint          sc, fu, fv, r, sf, diff, t;
      longint unsigned x, res, bitv, bg, dc, mix;
      shade_t          sh;
      sc = longint'($signed(cell_scale));
      if (sc == 0) sc = 2048;
      fu = cell_offset(longint'($signed(u)), sc);
      fv = cell_offset(longint'($signed(v)), sc);
      // Integer square root of the squared distance
      x = fu * fu + fv * fv;
      res = 0;
      bitv = 64'd1 << 32;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      r  = (radius > 17'h10000) ? 65536 : longint'(radius);
      sf = (softness > 17'h10000) ? 65536 : longint'(softness);
      if (sf == 0) sf = 1;
      diff = longint'(res) - r;
      if (diff <= 0) begin
        t = 65536;
      end else begin
        t = 65536 - (diff * 65536) / sf;
        if (t < 0) t = 0;
      end
      // Blend each channel from background to dot colour
      for (int ch = 0; ch < 3; ch++) begin
        bg  = bg_rgb[(2-ch)*CHANNEL_BITS +: CHANNEL_BITS];
        dc  = dot_rgb[(2-ch)*CHANNEL_BITS +: CHANNEL_BITS];
        mix = (bg * (65536 - t) + dc * t + 32768) >> 16;
        case (ch)
          0: sh.red   = mix[CHANNEL_BITS-1:0];
          1: sh.green = mix[CHANNEL_BITS-1:0];
          default: sh.blue = mix[CHANNEL_BITS-1:0];
        endcase
      end
      sh.cov = t[COV_W-1:0];
      pending_shades.push_back(sh);
    endfunction

    function void check_result(shade_t got);
      shade_t exp_sh;
      if (pending_shades.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing pending: r=%0d g=%0d b=%0d cov=%0d",
                   got.red, got.green, got.blue, got.cov);
        return;
      end
      exp_sh = pending_shades.pop_front();
      if (got.red !== exp_sh.red || got.green !== exp_sh.green ||
          got.blue !== exp_sh.blue || got.cov !== exp_sh.cov) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp r=%0d g=%0d b=%0d cov=%0d, got r=%0d g=%0d b=%0d cov=%0d",
                   exp_sh.red, exp_sh.green, exp_sh.blue, exp_sh.cov,
                   got.red, got.green, got.blue, got.cov);
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic                      busy_o;
  logic signed [COORD_W-1:0] u_coord_i = '0;
  logic signed [COORD_W-1:0] v_coord_i = '0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [2:0]                cfg_index_i = '0;
  logic [CFG_W-1:0]          cfg_data_i = '0;
  logic                      valid_o;
  logic [CHANNEL_BITS-1:0]   red_out_o;
  logic [CHANNEL_BITS-1:0]   green_out_o;
  logic [CHANNEL_BITS-1:0]   blue_out_o;
  logic [COV_W-1:0]          coverage_o;

  shade_scoreboard sb = new();
  int unsigned     cycles = 0;

  soft_dot_pattern_shader DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .u_coord_i, .v_coord_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .valid_o, .red_out_o, .green_out_o, .blue_out_o, .coverage_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watch accepted beats, register writes and results
  always @(posedge clk_i) begin
    shade_t got;
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_input(u_coord_i, v_coord_i);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (valid_o) begin
        got.red   = red_out_o;
        got.green = green_out_o;
        got.blue  = blue_out_o;
        got.cov   = coverage_o;
        sb.check_result(got);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    start_i   <= 1'b1;
    u_coord_i <= u;
    v_coord_i <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic idle_burst();
    start_i <= 1'b0;
    repeat ($urandom_range(1, 19)) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_shades.size() != 0) @(posedge clk_i);
  endtask

  // Hold valid high across back-to-back writes; the caller drops it
  task automatic write_cfg(logic [2:0] idx, logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Program every register for one phase; early phases hit the extremes
  task automatic program_phase(int p);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom());
    case (p)
      1: write_cfg(CFG_CELL_SCALE, {junk[CFG_W-1:16], 16'h0000});
      2: write_cfg(CFG_CELL_SCALE, {junk[CFG_W-1:16], 16'h8000});
      3: write_cfg(CFG_CELL_SCALE, {junk[CFG_W-1:16], 16'h7FFF});
      4: write_cfg(CFG_CELL_SCALE, 24'h000100);
      default: write_cfg(CFG_CELL_SCALE, CFG_W'($urandom()));
    endcase
    case (p)
      1: write_cfg(CFG_DOT_RADIUS, 24'd0);
      2: write_cfg(CFG_DOT_RADIUS, 24'd65536);
      3: write_cfg(CFG_DOT_RADIUS, {junk[CFG_W-1:17], 17'h1FFFF});
      default: write_cfg(CFG_DOT_RADIUS, CFG_W'($urandom()));
    endcase
    case (p)
      1: write_cfg(CFG_SOFTNESS, 24'd0);
      2: write_cfg(CFG_SOFTNESS, 24'd65536);
      3: write_cfg(CFG_SOFTNESS, 24'h1FFFF);
      4: write_cfg(CFG_SOFTNESS, 24'd1);
      default: write_cfg(CFG_SOFTNESS, CFG_W'($urandom_range(0, 20000)));
    endcase
    case (p)
      1: begin
        write_cfg(CFG_BG_RGB, 24'h000000);
        write_cfg(CFG_DOT_RGB, 24'hFFFFFF);
      end
      2: begin
        write_cfg(CFG_BG_RGB, 24'hFFFFFF);
        write_cfg(CFG_DOT_RGB, 24'h000000);
      end
      default: begin
        write_cfg(CFG_BG_RGB, CFG_W'($urandom()));
        write_cfg(CFG_DOT_RGB, CFG_W'($urandom()));
      end
    endcase
    // Unused indexes must leave every register alone
    write_cfg(3'($urandom_range(UNUSED_IDX_LO, 7)), CFG_W'($urandom()));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [COORD_W-1:0] corner[6];
    logic [COORD_W-1:0] u, v;
    corner = '{24'h000000, 24'h800000, 24'h7FFFFF, 24'h000001, 24'hFFFFFF, 24'h001000};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners under the reset register values
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 4; j++) send_item(corner[i], corner[(i + j) % 6]);
    drain();

    for (int p = 1; p < NUM_PHASES; p++) begin
      program_phase(p);
      for (int n = 0; n < PHASE_ITEMS + 12; n++) begin
        // Small coordinates now and then so scaling wraps less
        if ($urandom_range(0, 3) == 0) begin
          u = COORD_W'($signed($urandom_range(0, 8191)) - 4096);
          v = COORD_W'($signed($urandom_range(0, 8191)) - 4096);
        end else begin
          u = COORD_W'($urandom());
          v = COORD_W'($urandom());
        end
        send_item(u, v);
        if (p < NUM_PHASES - 1 && $urandom_range(0, 4) == 0) idle_burst();
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_shades.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
